// ===== sv/timer_event_deadline_queue_macros.svh =====
// Assertion macros shared by the timer event deadline queue RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef TIMER_EVENT_DEADLINE_QUEUE_MACROS_SVH
`define TIMER_EVENT_DEADLINE_QUEUE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TEDQ_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tedq assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define TEDQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tedq assertion failed");

`endif

// ===== sv/tedq_pkg.sv =====
// Types and constants for the timer event deadline queue.
// No dependencies; used by every module of the block.
package tedq_pkg;

    localparam int ID_W        = 3;
    localparam int DL_W        = 64;
    localparam int MODE_W      = 2;
    localparam int ID_COUNT    = 8;
    localparam int MAX_RESULTS = 8;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

    localparam logic [CNT_W-1:0] RES_MAX  = CNT_W'(MAX_RESULTS);
    localparam logic [CNT_W-1:0] RES_LAST = CNT_W'(MAX_RESULTS - 1);
    localparam logic [CNT_W-1:0] RES_ONE  = CNT_W'(1);

    localparam logic [MODE_W-1:0] MODE_START  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_STOP   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_EXPIRE = 2'd2;

    typedef struct packed {
        logic [ID_W-1:0] id;
        logic [DL_W-1:0] deadline;
    } t_slot;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FIND_RD,
        S_FIND_CMP,
        S_DROP_RD,
        S_DROP_WR,
        S_INS_BEGIN,
        S_INS_RD,
        S_INS_CMP,
        S_SHF_RD,
        S_SHF_WR,
        S_INS_WR,
        S_EXP_CHK,
        S_EMIT
    } t_state;

endpackage

// ===== sv/tedq_slot_ram.sv =====
// Slot memory of the deadline queue: one write port, one registered read port.
// Depends on tedq_pkg for the slot entry type.
module tedq_slot_ram #(
    parameter int DEPTH = 8,
    parameter int AW    = 3
) (
    input  logic            i_clk,
    input  logic            i_we,
    input  logic [AW-1:0]   i_waddr,
    input  tedq_pkg::t_slot i_wdata,
    input  logic [AW-1:0]   i_raddr,
    output tedq_pkg::t_slot o_rdata
);

    tedq_pkg::t_slot r_mem [DEPTH];
    tedq_pkg::t_slot r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/tedq_cmp.sv =====
// Shared 64-bit magnitude comparator with operand select.
// Insert scan tests new deadline < slot deadline; expire tests now < head.
module tedq_cmp (
    input  logic                      i_sel_insert,
    input  logic [tedq_pkg::DL_W-1:0] i_when,
    input  logic [tedq_pkg::DL_W-1:0] i_slot_dl,
    input  logic [tedq_pkg::DL_W-1:0] i_now,
    input  logic [tedq_pkg::DL_W-1:0] i_head,
    output logic                      o_lt
);

    logic [tedq_pkg::DL_W-1:0] w_a;
    logic [tedq_pkg::DL_W-1:0] w_b;

    always_comb begin
        if (i_sel_insert) begin
            w_a = i_when;
            w_b = i_slot_dl;
        end else begin
            w_a = i_now;
            w_b = i_head;
        end
    end

    assign o_lt = (w_a < w_b);

endmodule

// ===== sv/timer_event_deadline_queue.sv =====
// One sequencer walks the slot RAM entry by entry; each step is a read, then a compare or
// a move.
// One item at a time; the output register frees the input side once the item's last result is loaded.
// Reset (sync, active low) empties the queue and clears pending flags; RAM is not cleared.
module timer_event_deadline_queue #(
    parameter int EVENTS = 8
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [tedq_pkg::MODE_W-1:0]      i_mode,
    input  logic [tedq_pkg::ID_W-1:0]        i_event_id,
    input  logic [tedq_pkg::DL_W-1:0]        i_deadline,
    input  logic [tedq_pkg::DL_W-1:0]        i_now,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic                             o_expired_valid,
    output logic [tedq_pkg::ID_W-1:0]        o_expired_id,
    output logic [tedq_pkg::DL_W-1:0]        o_compare_value,
    output logic                             o_compare_enable,
    output logic                             o_last
);

    `include "timer_event_deadline_queue_macros.svh"

    localparam int CW = $clog2(EVENTS + 1);
    localparam int AW = $clog2(EVENTS);
    localparam logic [CW-1:0] LEN_FULL = CW'(EVENTS);
    localparam logic [CW-1:0] ONE      = CW'(1);

    tedq_pkg::t_state r_state, n_state;

    logic [tedq_pkg::MODE_W-1:0]  r_mode, n_mode;
    logic [tedq_pkg::ID_W-1:0]    r_id, n_id;
    logic [tedq_pkg::DL_W-1:0]    r_when, n_when;
    logic [tedq_pkg::DL_W-1:0]    r_now, n_now;
    logic [CW-1:0]                r_idx, n_idx;
    logic [CW-1:0]                r_pos, n_pos;
    logic [CW-1:0]                r_len, n_len;
    logic [tedq_pkg::CNT_W-1:0]   r_count, n_count;
    logic [tedq_pkg::ID_W-1:0]    r_hid, n_hid;
    logic                         r_popped, n_popped;
    logic [tedq_pkg::ID_COUNT-1:0] r_pending, n_pending;
    logic [tedq_pkg::DL_W-1:0]    r_head;
    logic [tedq_pkg::ID_W-1:0]    r_head_id;

    logic                         r_out_valid;
    logic                         r_exp_valid;
    logic [tedq_pkg::ID_W-1:0]    r_exp_id;
    logic [tedq_pkg::DL_W-1:0]    r_cmp_value;
    logic                         r_cmp_enable;
    logic                         r_last;

    logic             w_accept;
    logic             w_out_free;
    logic             w_lt;
    logic             w_found;
    logic             w_due;
    logic             w_go;
    logic             w_more;
    logic             w_emit;
    logic             w_we;
    logic [AW-1:0]    w_waddr;
    logic [AW-1:0]    w_raddr;
    tedq_pkg::t_slot  w_wdata;
    tedq_pkg::t_slot  w_rdata;

    tedq_slot_ram #(
        .DEPTH (EVENTS),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    tedq_cmp u_cmp (
        .i_sel_insert (r_state == tedq_pkg::S_INS_CMP),
        .i_when       (r_when),
        .i_slot_dl    (w_rdata.deadline),
        .i_now        (r_now),
        .i_head       (r_head),
        .o_lt         (w_lt)
    );

    assign o_in_stall = (r_state != tedq_pkg::S_IDLE);
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_found    = (w_rdata.id == r_id);
    // head due: queue not empty and head deadline <= now
    assign w_due      = (r_len != '0) && !w_lt;
    assign w_go       = (r_count < tedq_pkg::RES_MAX) && w_due;
    assign w_more     = (r_count < tedq_pkg::RES_LAST) && w_due;
    assign w_emit     = (r_state == tedq_pkg::S_EMIT) && w_out_free;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tedq_pkg::S_IDLE: begin
                if (w_accept) begin
                    unique case (i_mode) inside
                        tedq_pkg::MODE_START, tedq_pkg::MODE_STOP: begin
                            if (r_pending[i_event_id]) begin
                                n_state = tedq_pkg::S_FIND_RD;
                            end else if (i_mode == tedq_pkg::MODE_START) begin
                                n_state = tedq_pkg::S_INS_BEGIN;
                            end else begin
                                n_state = tedq_pkg::S_EMIT;
                            end
                        end
                        tedq_pkg::MODE_EXPIRE: n_state = tedq_pkg::S_EXP_CHK;
                        default:               n_state = tedq_pkg::S_EMIT;
                    endcase
                end
            end
            tedq_pkg::S_FIND_RD:  n_state = tedq_pkg::S_FIND_CMP;
            tedq_pkg::S_FIND_CMP: n_state = w_found ? tedq_pkg::S_DROP_RD : tedq_pkg::S_FIND_RD;
            tedq_pkg::S_DROP_RD: begin
                if ((r_idx + ONE) < r_len) begin
                    n_state = tedq_pkg::S_DROP_WR;
                end else if (r_mode == tedq_pkg::MODE_START) begin
                    n_state = tedq_pkg::S_INS_BEGIN;
                end else begin
                    n_state = tedq_pkg::S_EMIT;
                end
            end
            tedq_pkg::S_DROP_WR:   n_state = tedq_pkg::S_DROP_RD;
            tedq_pkg::S_INS_BEGIN: n_state = (r_len == LEN_FULL) ? tedq_pkg::S_EMIT
                                                                 : tedq_pkg::S_INS_RD;
            tedq_pkg::S_INS_RD:    n_state = (r_idx < r_len) ? tedq_pkg::S_INS_CMP
                                                             : tedq_pkg::S_SHF_RD;
            tedq_pkg::S_INS_CMP:   n_state = w_lt ? tedq_pkg::S_SHF_RD : tedq_pkg::S_INS_RD;
            tedq_pkg::S_SHF_RD:    n_state = (r_idx > r_pos) ? tedq_pkg::S_SHF_WR
                                                             : tedq_pkg::S_INS_WR;
            tedq_pkg::S_SHF_WR:    n_state = tedq_pkg::S_SHF_RD;
            tedq_pkg::S_INS_WR:    n_state = tedq_pkg::S_EMIT;
            tedq_pkg::S_EXP_CHK:   n_state = w_go ? tedq_pkg::S_DROP_RD : tedq_pkg::S_EMIT;
            tedq_pkg::S_EMIT: begin
                if (w_out_free) begin
                    n_state = (r_popped && w_more) ? tedq_pkg::S_EXP_CHK : tedq_pkg::S_IDLE;
                end
            end
            default: n_state = tedq_pkg::S_IDLE;
        endcase
    end

    // datapath and RAM controls
    always_comb begin
        n_mode    = r_mode;
        n_id      = r_id;
        n_when    = r_when;
        n_now     = r_now;
        n_idx     = r_idx;
        n_pos     = r_pos;
        n_len     = r_len;
        n_count   = r_count;
        n_hid     = r_hid;
        n_popped  = r_popped;
        n_pending = r_pending;
        w_we      = 1'b0;
        w_waddr   = r_idx[AW-1:0];
        w_wdata   = w_rdata;
        w_raddr   = r_idx[AW-1:0];
        unique case (r_state)
            tedq_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_mode   = i_mode;
                    n_id     = i_event_id;
                    n_when   = i_deadline;
                    n_now    = i_now;
                    n_idx    = '0;
                    n_count  = '0;
                    n_popped = 1'b0;
                    n_hid    = i_event_id;
                end
            end
            tedq_pkg::S_FIND_CMP: begin
                if (!w_found) begin
                    n_idx = r_idx + ONE;
                end
            end
            tedq_pkg::S_DROP_RD: begin
                w_raddr = AW'(r_idx + ONE);
                if (!((r_idx + ONE) < r_len)) begin
                    n_len            = r_len - ONE;
                    n_pending[r_hid] = 1'b0;
                end
            end
            tedq_pkg::S_DROP_WR: begin
                w_we  = 1'b1;
                n_idx = r_idx + ONE;
            end
            tedq_pkg::S_INS_BEGIN: n_idx = '0;
            tedq_pkg::S_INS_RD: begin
                if (!(r_idx < r_len)) begin
                    n_pos = r_len;
                    n_idx = r_len;
                end
            end
            tedq_pkg::S_INS_CMP: begin
                if (w_lt) begin
                    n_pos = r_idx;
                    n_idx = r_len;
                end else begin
                    n_idx = r_idx + ONE;
                end
            end
            tedq_pkg::S_SHF_RD: w_raddr = AW'(r_idx - ONE);
            tedq_pkg::S_SHF_WR: begin
                w_we  = 1'b1;
                n_idx = r_idx - ONE;
            end
            tedq_pkg::S_INS_WR: begin
                w_we             = 1'b1;
                w_waddr          = r_pos[AW-1:0];
                w_wdata.id       = r_id;
                w_wdata.deadline = r_when;
                n_len            = r_len + ONE;
                n_pending[r_id]  = 1'b1;
            end
            tedq_pkg::S_EXP_CHK: begin
                if (w_go) begin
                    n_idx    = '0;
                    n_hid    = r_head_id;
                    n_popped = 1'b1;
                end
            end
            tedq_pkg::S_EMIT: begin
                if (w_out_free && r_popped && w_more) begin
                    n_count = r_count + tedq_pkg::RES_ONE;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tedq_pkg::S_IDLE;
            r_len       <= '0;
            r_count     <= '0;
            r_pending   <= '0;
            r_popped    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_len       <= n_len;
            r_count     <= n_count;
            r_pending   <= n_pending;
            r_popped    <= n_popped;
            r_out_valid <= w_emit ? 1'b1 : (r_out_valid && i_out_stall);
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode <= n_mode;
        r_id   <= n_id;
        r_when <= n_when;
        r_now  <= n_now;
        r_idx  <= n_idx;
        r_pos  <= n_pos;
        r_hid  <= n_hid;
        // shadow of slot 0 for the comparator output and expire checks
        if (w_we && (w_waddr == '0)) begin
            r_head    <= w_wdata.deadline;
            r_head_id <= w_wdata.id;
        end
        if (w_emit) begin
            r_exp_valid  <= r_popped;
            r_exp_id     <= r_popped ? r_hid : '0;
            r_cmp_value  <= (r_len != '0) ? r_head : '0;
            r_cmp_enable <= (r_len != '0);
            r_last       <= !(r_popped && w_more);
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_expired_valid  = r_exp_valid;
    assign o_expired_id     = r_exp_id;
    assign o_compare_value  = r_cmp_value;
    assign o_compare_enable = r_cmp_enable;
    assign o_last           = r_last;

    `TEDQ_ASSERT_IMPL(a_len_bound, i_clk, i_rst_n, 1'b1, r_len <= LEN_FULL)
    `TEDQ_ASSERT_IMPL(a_pending_matches_len, i_clk, i_rst_n, 1'b1, $countones(r_pending) == r_len)
    `TEDQ_ASSERT_IMPL(a_find_in_range, i_clk, i_rst_n, r_state == tedq_pkg::S_FIND_CMP, r_idx < r_len)
    `TEDQ_ASSERT_IMPL(a_empty_zero_cmp, i_clk, i_rst_n, o_out_valid && !o_compare_enable, o_compare_value == '0)
    `TEDQ_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, w_accept, r_state != tedq_pkg::S_IDLE)

endmodule
